/* rtl/core/zcdp_pkg.sv */
package zcdp_pkg;

  // Record layout
  localparam int HDR_LEN       = 46;
  localparam int HDR_KEEP      = HDR_LEN - 1;
  localparam int POS_W         = 18;
  localparam logic [31:0] CD_SIGNATURE = 32'h0201_4b50;

  localparam int OFF_SIG       = 0;
  localparam int OFF_METHOD    = 10;
  localparam int OFF_CRC       = 16;
  localparam int OFF_PACKED    = 20;
  localparam int OFF_PLAIN     = 24;
  localparam int OFF_NAME_LEN  = 28;
  localparam int OFF_EXTRA_LEN = 30;
  localparam int OFF_CMT_LEN   = 32;
  localparam int OFF_LOCAL     = 42;

  // Register map
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_EXPECTED_ENTRIES = 1'b0;

  // Output queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_ENTRY = 3'd0,
    KIND_NAME  = 3'd1,
    KIND_DONE  = 3'd2,
    KIND_BAD   = 3'd3,
    KIND_TRUNC = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] entry_index;
    logic [15:0] method;
    logic [31:0] crc_value;
    logic [31:0] packed_size;
    logic [31:0] plain_size;
    logic [15:0] name_length;
    logic [31:0] local_offset;
    logic [31:0] pool_offset;
    logic [7:0]  name_char;
  } result_t;

  // All results caused by one input byte
  typedef struct packed {
    logic        has_pri;
    result_t     pri;
    logic        has_term;
    kind_t       term_kind;
    logic [15:0] term_index;
  } queue_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

/* rtl/core/zcdp_byte_if.sv */
interface zcdp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/core/zcdp_result_if.sv */
interface zcdp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] entry_index;
  logic [15:0] method;
  logic [31:0] crc_value;
  logic [31:0] packed_size;
  logic [31:0] plain_size;
  logic [15:0] name_length;
  logic [31:0] local_offset;
  logic [31:0] pool_offset;
  logic [7:0]  name_char;

  modport source (
    output valid, output kind, output entry_index, output method, output crc_value,
    output packed_size, output plain_size, output name_length, output local_offset,
    output pool_offset, output name_char, input ready
  );
  modport sink (
    input valid, input kind, input entry_index, input method, input crc_value,
    input packed_size, input plain_size, input name_length, input local_offset,
    input pool_offset, input name_char, output ready
  );
endinterface

/* rtl/core/zip_central_directory_parser_unit.sv */
// Channel     Dir  Payload                                     Accepted when
// byte_in     in   data_byte[7:0], last_byte                   valid && ready
// result_out  out  kind, entry_index, record fields, name_char  valid && ready
// apb         in   paddr[2:0], pwdata[31:0] -> prdata[31:0]    psel && penable && pwrite
//
// One byte is taken per cycle; its state update completes at the accepting edge and
// its results go to a four-slot queue, seen on the output the next cycle at earliest.
// Each byte fills at most one slot; only the last byte of a stream can carry two
// results (record or name result, then the end result), shown on the output one after the other.
// Input ready drops only while the queue is full. Reset clears all control state;
// the last byte of a stream also returns the parser to its start state.
module zip_central_directory_parser_unit (
  input  logic                              clk,
  input  logic                              rst,
  zcdp_byte_if.sink                         byte_in,
  zcdp_result_if.source                     result_out,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [zcdp_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam logic [zcdp_pkg::POS_W-1:0] HDR_END = zcdp_pkg::POS_W'(zcdp_pkg::HDR_LEN);
  localparam logic [zcdp_pkg::POS_W-1:0] HDR_LAST =
    zcdp_pkg::POS_W'(zcdp_pkg::HDR_LEN - 1);

  // Registers
  logic [15:0]                 expected_entries;
  logic [zcdp_pkg::POS_W-1:0]  record_position;
  logic [zcdp_pkg::POS_W-1:0]  name_end;
  logic [zcdp_pkg::POS_W-1:0]  rec_end;
  logic [15:0]                 entries_done;
  logic [31:0]                 pool_running;
  logic                        failed_flag;
  logic [7:0]                  hdr_sr [zcdp_pkg::HDR_KEEP];

  logic [zcdp_pkg::POS_W-1:0]  record_position_next;
  logic [zcdp_pkg::POS_W-1:0]  name_end_next;
  logic [zcdp_pkg::POS_W-1:0]  rec_end_next;
  logic [15:0]                 entries_done_next;
  logic [31:0]                 pool_running_next;
  logic                        failed_flag_next;

  logic                        in_acc;
  logic                        cfg_wr;
  logic                        active;
  logic                        in_hdr;
  logic                        shift_en;
  logic [31:0]                 sig;
  logic [15:0]                 nl;
  logic [15:0]                 el;
  logic [15:0]                 cl;
  zcdp_pkg::queue_entry_t      qe;
  zcdp_pkg::queue_status_t     qstat;

  assign in_acc = byte_in.valid && byte_in.ready;
  assign byte_in.ready = !qstat.full;

  // Config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[zcdp_pkg::CFG_ADDR_W-1] == zcdp_pkg::REG_EXPECTED_ENTRIES);
  assign prdata = (paddr[zcdp_pkg::CFG_ADDR_W-1] == zcdp_pkg::REG_EXPECTED_ENTRIES) ?
                  {16'd0, expected_entries} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_entries <= '0;
    end else if (cfg_wr) begin
      expected_entries <= pwdata[15:0];
    end
  end

  // Header taps
  assign sig = {hdr_sr[zcdp_pkg::OFF_SIG+3], hdr_sr[zcdp_pkg::OFF_SIG+2],
                hdr_sr[zcdp_pkg::OFF_SIG+1], hdr_sr[zcdp_pkg::OFF_SIG]};
  assign nl  = {hdr_sr[zcdp_pkg::OFF_NAME_LEN+1], hdr_sr[zcdp_pkg::OFF_NAME_LEN]};
  assign el  = {hdr_sr[zcdp_pkg::OFF_EXTRA_LEN+1], hdr_sr[zcdp_pkg::OFF_EXTRA_LEN]};
  assign cl  = {hdr_sr[zcdp_pkg::OFF_CMT_LEN+1], hdr_sr[zcdp_pkg::OFF_CMT_LEN]};

  assign active = !failed_flag && (entries_done < expected_entries);
  assign in_hdr = record_position < HDR_END;

  // Per-byte parse step
  always_comb begin
    record_position_next = record_position;
    name_end_next        = name_end;
    rec_end_next         = rec_end;
    entries_done_next    = entries_done;
    pool_running_next    = pool_running;
    failed_flag_next     = failed_flag;
    shift_en             = 1'b0;
    qe                   = '0;

    if (in_acc && active) begin
      if (in_hdr) begin
        shift_en = 1'b1;
        if (record_position == HDR_LAST) begin
          if (sig != zcdp_pkg::CD_SIGNATURE) begin
            failed_flag_next = 1'b1;
          end else begin
            qe.has_pri          = 1'b1;
            qe.pri.kind         = zcdp_pkg::KIND_ENTRY;
            qe.pri.entry_index  = entries_done;
            qe.pri.method       = {hdr_sr[zcdp_pkg::OFF_METHOD+1],
                                   hdr_sr[zcdp_pkg::OFF_METHOD]};
            qe.pri.crc_value    = {hdr_sr[zcdp_pkg::OFF_CRC+3], hdr_sr[zcdp_pkg::OFF_CRC+2],
                                   hdr_sr[zcdp_pkg::OFF_CRC+1], hdr_sr[zcdp_pkg::OFF_CRC]};
            qe.pri.packed_size  = {hdr_sr[zcdp_pkg::OFF_PACKED+3],
                                   hdr_sr[zcdp_pkg::OFF_PACKED+2],
                                   hdr_sr[zcdp_pkg::OFF_PACKED+1],
                                   hdr_sr[zcdp_pkg::OFF_PACKED]};
            qe.pri.plain_size   = {hdr_sr[zcdp_pkg::OFF_PLAIN+3],
                                   hdr_sr[zcdp_pkg::OFF_PLAIN+2],
                                   hdr_sr[zcdp_pkg::OFF_PLAIN+1],
                                   hdr_sr[zcdp_pkg::OFF_PLAIN]};
            qe.pri.name_length  = nl;
            // top byte of the local offset is the byte arriving now
            qe.pri.local_offset = {byte_in.data_byte, hdr_sr[zcdp_pkg::OFF_LOCAL+2],
                                   hdr_sr[zcdp_pkg::OFF_LOCAL+1],
                                   hdr_sr[zcdp_pkg::OFF_LOCAL]};
            qe.pri.pool_offset  = pool_running;
            pool_running_next   = pool_running + 32'(nl) + 32'd1;
            name_end_next       = HDR_END + zcdp_pkg::POS_W'(nl);
            rec_end_next        = HDR_END + zcdp_pkg::POS_W'(nl) + zcdp_pkg::POS_W'(el) +
                                  zcdp_pkg::POS_W'(cl);
            // record with no trailing bytes ends with its header
            if ((nl == 16'd0) && (el == 16'd0) && (cl == 16'd0)) begin
              entries_done_next    = entries_done + 16'd1;
              record_position_next = '0;
            end else begin
              record_position_next = HDR_END;
            end
          end
        end else begin
          record_position_next = record_position + 1'b1;
        end
      end else begin
        if (record_position < name_end) begin
          qe.has_pri       = 1'b1;
          qe.pri.kind      = zcdp_pkg::KIND_NAME;
          qe.pri.entry_index = entries_done;
          qe.pri.name_char = byte_in.data_byte;
        end
        if ((record_position + 1'b1) == rec_end) begin
          entries_done_next    = entries_done + 16'd1;
          record_position_next = '0;
        end else begin
          record_position_next = record_position + 1'b1;
        end
      end
    end

    // End of stream: report and rewind
    if (in_acc && byte_in.last_byte) begin
      qe.has_term   = 1'b1;
      qe.term_index = entries_done_next;
      if (failed_flag_next) begin
        qe.term_kind = zcdp_pkg::KIND_BAD;
      end else if (entries_done_next >= expected_entries) begin
        qe.term_kind = zcdp_pkg::KIND_DONE;
      end else if (record_position_next < HDR_END) begin
        qe.term_kind = zcdp_pkg::KIND_BAD;
      end else begin
        qe.term_kind = zcdp_pkg::KIND_TRUNC;
      end
      record_position_next = '0;
      name_end_next        = '0;
      rec_end_next         = '0;
      entries_done_next    = '0;
      pool_running_next    = '0;
      failed_flag_next     = 1'b0;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      record_position <= '0;
      name_end        <= '0;
      rec_end         <= '0;
      entries_done    <= '0;
      pool_running    <= '0;
      failed_flag     <= 1'b0;
    end else begin
      record_position <= record_position_next;
      name_end        <= name_end_next;
      rec_end         <= rec_end_next;
      entries_done    <= entries_done_next;
      pool_running    <= pool_running_next;
      failed_flag     <= failed_flag_next;
    end
  end

  // Header byte shift line
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < zcdp_pkg::HDR_KEEP - 1; i++) begin
        hdr_sr[i] <= hdr_sr[i+1];
      end
      hdr_sr[zcdp_pkg::HDR_KEEP-1] <= byte_in.data_byte;
    end
  end

  zcdp_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (qe.has_pri || qe.has_term),
    .push_data (qe),
    .status    (qstat),
    .out_ch    (result_out)
  );

  // Checks
  a_fail_sticky: assert property (@(posedge clk) disable iff (rst)
    (failed_flag && !(in_acc && byte_in.last_byte)) |=> failed_flag)
    else $error("failed flag dropped before end of stream");

  a_pos_in_record: assert property (@(posedge clk) disable iff (rst)
    (record_position >= HDR_END) |-> (record_position < rec_end))
    else $error("record position ran past end of record");

  a_stream_rewind: assert property (@(posedge clk) disable iff (rst)
    (in_acc && byte_in.last_byte) |=>
      (record_position == '0) && (entries_done == '0) && !failed_flag &&
      (pool_running == '0))
    else $error("parser not rewound after last byte");

endmodule

/* rtl/core/zcdp_result_queue.sv */
module zcdp_result_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  zcdp_pkg::queue_entry_t push_data,
  output zcdp_pkg::queue_status_t status,
  zcdp_result_if.source          out_ch
);

  zcdp_pkg::queue_entry_t            slot [zcdp_pkg::QUEUE_DEPTH];
  logic [zcdp_pkg::QPTR_W-1:0]       wr_ptr;
  logic [zcdp_pkg::QPTR_W-1:0]       rd_ptr;
  logic [zcdp_pkg::QCNT_W-1:0]       count;
  logic                              term_phase;

  zcdp_pkg::queue_entry_t head;
  zcdp_pkg::result_t      shown;
  logic                   send_term;
  logic                   beat;
  logic                   pop;

  assign head      = slot[rd_ptr];
  assign send_term = !head.has_pri || term_phase;
  assign beat      = out_ch.valid && out_ch.ready;
  assign pop       = beat && (send_term || !head.has_term);

  assign status.empty = (count == '0);
  assign status.full  = (count == zcdp_pkg::QCNT_W'(zcdp_pkg::QUEUE_DEPTH));

  // Head request: record result first, then the end-of-stream result
  always_comb begin
    if (send_term) begin
      shown             = '0;
      shown.kind        = head.term_kind;
      shown.entry_index = head.term_index;
    end else begin
      shown = head.pri;
    end
  end

  assign out_ch.valid        = !status.empty;
  assign out_ch.kind         = shown.kind;
  assign out_ch.entry_index  = shown.entry_index;
  assign out_ch.method       = shown.method;
  assign out_ch.crc_value    = shown.crc_value;
  assign out_ch.packed_size  = shown.packed_size;
  assign out_ch.plain_size   = shown.plain_size;
  assign out_ch.name_length  = shown.name_length;
  assign out_ch.local_offset = shown.local_offset;
  assign out_ch.pool_offset  = shown.pool_offset;
  assign out_ch.name_char    = shown.name_char;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
      term_phase <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
      if (pop) begin
        term_phase <= 1'b0;
      end else if (beat) begin
        term_phase <= 1'b1;
      end
    end
  end

endmodule

/* dv/zip_central_directory_parser_unit_test.sv */
`timescale 1ns / 100ps

module zip_central_directory_parser_unit_test;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_BYTES   = 350;
  localparam int STREAM_CAP     = 300;

  // Tracks the parser state and holds the results each accepted byte should cause
  class dir_entry_tracker;
    logic [15:0] entry_limit;
    int unsigned pos;
    logic [7:0]  hdr [zcdp_pkg::HDR_LEN];
    logic [15:0] name_count;
    logic [15:0] extra_len;
    logic [15:0] cmt_len;
    logic [15:0] done_count;
    logic [31:0] pool;
    bit          failed;
    zcdp_pkg::result_t due_results [$];
    int          errors;
    int          kind_seen [5];

    function void clear_stream();
      pos = 0;
      foreach (hdr[i]) hdr[i] = '0;
      name_count = '0;
      extra_len  = '0;
      cmt_len    = '0;
      done_count = '0;
      pool       = '0;
      failed     = 1'b0;
    endfunction

    function void reset();
      entry_limit = '0;
      clear_stream();
      due_results.delete();
    endfunction

    // little-endian header fields
    function logic [15:0] hdr16(int at);
      return {hdr[at + 1], hdr[at]};
    endfunction

    function logic [31:0] hdr32(int at);
      return {hdr16(at + 2), hdr16(at)};
    endfunction

    function zcdp_pkg::result_t blank(zcdp_pkg::kind_t k);
      zcdp_pkg::result_t r;
      r = '0;
      r.kind = k;
      r.entry_index = done_count;
      return r;
    endfunction

    function void take_byte(logic [7:0] d, logic last);
      zcdp_pkg::result_t r;
      zcdp_pkg::kind_t   term;
      if (!failed && done_count < entry_limit) begin
        if (pos < zcdp_pkg::HDR_LEN) begin
          hdr[pos] = d;
          pos++;
          if (pos == zcdp_pkg::HDR_LEN) begin
            if (hdr32(zcdp_pkg::OFF_SIG) != zcdp_pkg::CD_SIGNATURE) begin
              failed = 1'b1;
            end else begin
              name_count = hdr16(zcdp_pkg::OFF_NAME_LEN);
              extra_len  = hdr16(zcdp_pkg::OFF_EXTRA_LEN);
              cmt_len    = hdr16(zcdp_pkg::OFF_CMT_LEN);
              r = blank(zcdp_pkg::KIND_ENTRY);
              r.method       = hdr16(zcdp_pkg::OFF_METHOD);
              r.crc_value    = hdr32(zcdp_pkg::OFF_CRC);
              r.packed_size  = hdr32(zcdp_pkg::OFF_PACKED);
              r.plain_size   = hdr32(zcdp_pkg::OFF_PLAIN);
              r.name_length  = name_count;
              r.local_offset = hdr32(zcdp_pkg::OFF_LOCAL);
              r.pool_offset  = pool;
              pool = pool + 32'(name_count) + 32'd1;
              due_results.push_back(r);
            end
          end
        end else begin
          if (pos - zcdp_pkg::HDR_LEN < name_count) begin
            r = blank(zcdp_pkg::KIND_NAME);
            r.name_char = d;
            due_results.push_back(r);
          end
          pos++;
        end
        // record complete once header, name, extra and comment are consumed
        if (!failed && pos >= zcdp_pkg::HDR_LEN &&
            pos >= zcdp_pkg::HDR_LEN + int'(name_count) + int'(extra_len) + int'(cmt_len))
        begin
          done_count++;
          pos = 0;
        end
      end
      if (last) begin
        if (failed) term = zcdp_pkg::KIND_BAD;
        else if (done_count >= entry_limit) term = zcdp_pkg::KIND_DONE;
        else if (pos < zcdp_pkg::HDR_LEN) term = zcdp_pkg::KIND_BAD;
        else term = zcdp_pkg::KIND_TRUNC;
        due_results.push_back(blank(term));
        clear_stream();
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(zcdp_pkg::result_t got);
      zcdp_pkg::result_t want;
      if (due_results.size() == 0) begin
        report("unexpected result kind", 32'(got.kind), '0);
        return;
      end
      want = due_results.pop_front();
      if (want.kind <= zcdp_pkg::KIND_TRUNC) kind_seen[int'(want.kind)]++;
      if (got.kind !== want.kind) report("kind", 32'(got.kind), 32'(want.kind));
      if (got.entry_index !== want.entry_index)
        report("entry_index", 32'(got.entry_index), 32'(want.entry_index));
      if (got.method !== want.method) report("method", 32'(got.method), 32'(want.method));
      if (got.crc_value !== want.crc_value) report("crc_value", got.crc_value, want.crc_value);
      if (got.packed_size !== want.packed_size)
        report("packed_size", got.packed_size, want.packed_size);
      if (got.plain_size !== want.plain_size)
        report("plain_size", got.plain_size, want.plain_size);
      if (got.name_length !== want.name_length)
        report("name_length", 32'(got.name_length), 32'(want.name_length));
      if (got.local_offset !== want.local_offset)
        report("local_offset", got.local_offset, want.local_offset);
      if (got.pool_offset !== want.pool_offset)
        report("pool_offset", got.pool_offset, want.pool_offset);
      if (got.name_char !== want.name_char)
        report("name_char", 32'(got.name_char), 32'(want.name_char));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  zcdp_byte_if   byte_ch ();
  zcdp_result_if res_ch ();

  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [zcdp_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0]                     pwdata;
  logic [31:0]                     prdata;
  logic                            pready;

  dir_entry_tracker tracker = new();

  logic [7:0] dir_bytes [$];
  bit         calm;
  int         hold_asked;
  int         hold_given;
  int         hold_left;
  int         stall_left;
  int         idle_cycles;
  int         bytes_taken;
  int         stream_no;
  int         random_bytes;
  logic [15:0] next_entries;
  zcdp_pkg::result_t got;
  bit         progress;

  zip_central_directory_parser_unit uut (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_ch),
    .result_out (res_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else if (hold_given < hold_asked) begin
      hold_given++;
      hold_left = HOLD_CYCLES - 1;
      res_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Monitor: check results, feed accepted bytes to the tracker, watchdog
  always @(posedge clk) begin
    if (!rst) begin
      progress = 1'b0;
      if (res_ch.valid && res_ch.ready) begin
        got.kind         = zcdp_pkg::kind_t'(res_ch.kind);
        got.entry_index  = res_ch.entry_index;
        got.method       = res_ch.method;
        got.crc_value    = res_ch.crc_value;
        got.packed_size  = res_ch.packed_size;
        got.plain_size   = res_ch.plain_size;
        got.name_length  = res_ch.name_length;
        got.local_offset = res_ch.local_offset;
        got.pool_offset  = res_ch.pool_offset;
        got.name_char    = res_ch.name_char;
        tracker.check_result(got);
        progress = 1'b1;
      end
      if (byte_ch.valid && byte_ch.ready) begin
        tracker.take_byte(byte_ch.data_byte, byte_ch.last_byte);
        bytes_taken++;
        progress = 1'b1;
      end
      if (psel && penable && pwrite && pready) progress = 1'b1;
      if (progress) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("zip_central_directory_parser_unit_test failed");
        $finish;
      end
    end
  end

  // One 46-byte header plus its name/extra/comment bytes; fill < 0 means random
  function automatic void add_record(bit good_sig, logic [15:0] nlen, logic [15:0] elen,
                                     logic [15:0] clen, int fill);
    logic [7:0] h [zcdp_pkg::HDR_LEN];
    foreach (h[i]) h[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    {h[zcdp_pkg::OFF_SIG + 3], h[zcdp_pkg::OFF_SIG + 2],
     h[zcdp_pkg::OFF_SIG + 1], h[zcdp_pkg::OFF_SIG]} = zcdp_pkg::CD_SIGNATURE;
    if (!good_sig) h[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
    {h[zcdp_pkg::OFF_NAME_LEN + 1], h[zcdp_pkg::OFF_NAME_LEN]}   = nlen;
    {h[zcdp_pkg::OFF_EXTRA_LEN + 1], h[zcdp_pkg::OFF_EXTRA_LEN]} = elen;
    {h[zcdp_pkg::OFF_CMT_LEN + 1], h[zcdp_pkg::OFF_CMT_LEN]}     = clen;
    foreach (h[i]) dir_bytes.push_back(h[i]);
    for (int i = 0; i < int'(nlen) + int'(elen) + int'(clen) && dir_bytes.size() < STREAM_CAP;
         i++)
      dir_bytes.push_back(8'($urandom));
  endfunction

  function automatic void cut_to(int n);
    while (dir_bytes.size() > n) void'(dir_bytes.pop_back());
  endfunction

  // Mostly well-formed directories; some end early, break a signature or cut short
  function automatic void build_random_stream(int entries);
    int          n_rec;
    int          mode;
    int          bad_at;
    logic [15:0] len [3];
    dir_bytes.delete();
    mode = $urandom_range(0, 19);
    n_rec = (entries > 6) ? $urandom_range(1, 3) : entries;
    if (mode == 0 && n_rec > 0) n_rec--;
    bad_at = (mode == 1) ? $urandom_range(0, n_rec) : -1;
    for (int r = 0; r < n_rec; r++) begin
      foreach (len[k]) begin
        case ($urandom_range(0, 19))
          0:       len[k] = 16'($urandom);
          1, 2:    len[k] = '0;
          default: len[k] = 16'($urandom_range(1, (k == 0) ? 8 : 3));
        endcase
      end
      add_record(r != bad_at, len[0], len[1], len[2], -1);
    end
    if (mode inside {2, 3, 4}) begin
      if (dir_bytes.size() > 0) cut_to($urandom_range(1, dir_bytes.size()));
    end else begin
      repeat ($urandom_range(0, 3)) dir_bytes.push_back(8'($urandom));
    end
    if (dir_bytes.size() == 0) dir_bytes.push_back(8'($urandom));
  endfunction

  // Send dir_bytes, flagging the final one as the end of the directory
  task automatic send_stream();
    int gap;
    for (int i = 0; i < dir_bytes.size(); i++) begin
      if (!calm && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 16);
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      byte_ch.valid     <= 1'b1;
      byte_ch.data_byte <= dir_bytes[i];
      byte_ch.last_byte <= (i == dir_bytes.size() - 1);
      do @(posedge clk); while (!byte_ch.ready);
    end
  endtask

  // Stop sending and wait for every expected result, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    byte_ch.valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_entries(logic [15:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= zcdp_pkg::CFG_ADDR_W'(4 * int'(zcdp_pkg::REG_EXPECTED_ENTRIES));
    pwdata  <= {16'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.entry_limit = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.last_byte = 1'b0;
    res_ch.ready      = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    tracker.reset();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // entry count is zero out of reset: any bytes end in done
    dir_bytes = '{8'h00, 8'hFF, 8'h5A};
    send_stream();

    // stream ends inside the first header
    wait_idle();
    write_entries(16'd1);
    dir_bytes.delete();
    repeat (10) dir_bytes.push_back(8'($urandom));
    send_stream();

    // one complete record with name, extra and comment, then trailing bytes
    dir_bytes.delete();
    add_record(1'b1, 16'd2, 16'd1, 16'd1, -1);
    dir_bytes.push_back(8'h00);
    dir_bytes.push_back(8'hFF);
    send_stream();

    // all-ones header ends the stream at a record boundary with one more due
    wait_idle();
    write_entries(16'd2);
    dir_bytes.delete();
    add_record(1'b1, 16'd0, 16'd0, 16'd0, 8'hFF);
    send_stream();

    // broken signature, later bytes ignored
    wait_idle();
    write_entries(16'd1);
    dir_bytes.delete();
    add_record(1'b0, 16'd3, 16'd0, 16'd0, -1);
    repeat (4) dir_bytes.push_back(8'($urandom));
    send_stream();

    // maximum lengths on an all-zero header, stream ends inside the name
    wait_idle();
    write_entries(16'hFFFF);
    dir_bytes.delete();
    add_record(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00);
    cut_to(zcdp_pkg::HDR_LEN + 3);
    send_stream();

    // second record ends inside its comment
    wait_idle();
    write_entries(16'd3);
    dir_bytes.delete();
    add_record(1'b1, 16'd1, 16'd2, 16'd0, -1);
    add_record(1'b1, 16'd0, 16'd0, 16'd2, -1);
    cut_to(dir_bytes.size() - 1);
    send_stream();

    // last byte completes the last expected record
    wait_idle();
    write_entries(16'd2);
    dir_bytes.delete();
    add_record(1'b1, 16'd3, 16'd0, 16'd1, -1);
    add_record(1'b1, 16'd1, 16'd2, 16'd0, -1);
    send_stream();

    // random directories
    while (random_bytes < RANDOM_BYTES) begin
      calm = (random_bytes >= RANDOM_BYTES - 100);
      case ($urandom_range(0, 9))
        0:       next_entries = '0;
        1:       next_entries = 16'hFFFF;
        2:       next_entries = 16'($urandom);
        default: next_entries = 16'($urandom_range(1, 5));
      endcase
      if (stream_no == 1 || stream_no == 3) next_entries = 16'd5;
      if (next_entries != tracker.entry_limit || $urandom_range(0, 3) == 0) begin
        wait_idle();
        write_entries(next_entries);
      end
      build_random_stream(int'(tracker.entry_limit));
      // long result-side hold-off while this stream keeps coming
      if (stream_no == 1 || stream_no == 3) hold_asked++;
      send_stream();
      random_bytes += dir_bytes.size();
      stream_no++;
    end

    wait_idle();
    repeat (10) @(negedge clk);
    $display("%0d bytes in %0d random directories plus directed cases", bytes_taken, stream_no);
    $display("results: %0d entries, %0d name bytes, %0d done, %0d bad/short, %0d truncated",
             tracker.kind_seen[0], tracker.kind_seen[1], tracker.kind_seen[2],
             tracker.kind_seen[3], tracker.kind_seen[4]);
    if (tracker.errors == 0) begin
      $display("zip_central_directory_parser_unit_test passed");
    end else begin
      $display("zip_central_directory_parser_unit_test failed");
    end
    $finish;
  end

endmodule
